FILE: rtl/core/foreground_bounding_box_assert.svh
// Assertion macros shared by the foreground bounding box RTL.
// Assertions are active in simulation and empty for synthesis.
`ifndef FOREGROUND_BOUNDING_BOX_ASSERT_SVH
`define FOREGROUND_BOUNDING_BOX_ASSERT_SVH
`ifndef SYNTHESIS
`define FBB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FBB_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FBB_ASSERT(label, clk, rst, prop, msg)
`define FBB_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

FILE: rtl/core/fbb_pkg.sv
// Types and constants of the foreground bounding box.
// No dependencies; used by every module of the block.
package fbb_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int SIZE_W      = 13;
  localparam int OUT_W       = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MATCH_MODE   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_KEY_RED      = 3'd3,
    REG_KEY_GREEN    = 3'd4,
    REG_KEY_BLUE     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

endpackage

FILE: rtl/core/fbb_front.sv
// Front end: accepts pixels and classifies each as foreground or background.
// Depends on fbb_pkg; holds the match mode and key color registers.
module fbb_front import fbb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  pixel_t  pixel,
  input  logic    q_full,
  output logic    q_push,
  output logic    q_fg
);

  logic       match_mode;
  logic [7:0] key_red;
  logic [7:0] key_green;
  logic [7:0] key_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode <= 1'b0;
      key_red    <= '0;
      key_green  <= '0;
      key_blue   <= '0;
    end else if (cfg.wr) begin
      case (cfg.index)
        REG_MATCH_MODE: match_mode <= cfg.data[0];
        REG_KEY_RED:    key_red    <= cfg.data[7:0];
        REG_KEY_GREEN:  key_green  <= cfg.data[7:0];
        REG_KEY_BLUE:   key_blue   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_tready = !q_full;
    q_push   = s_tvalid && !q_full;
    if (match_mode) begin
      q_fg = (pixel.red != key_red) || (pixel.green != key_green) ||
             (pixel.blue != key_blue);
    end else begin
      q_fg = (pixel.alpha != 8'd0);
    end
  end

endmodule

FILE: rtl/core/fbb_queue.sv
// Short queue of foreground flags between the front end and the back end.
// Depends on fbb_pkg and the assertion macro header.
`include "foreground_bounding_box_assert.svh"
module fbb_queue import fbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_fg,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output logic head_fg
);

  logic                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full       = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_fg    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_fg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `FBB_ASSERT(a_count_bound, clk, rst, count <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH), "queue overfilled")
  `FBB_ASSERT_NEVER(a_pop_empty, clk, rst, pop && !head_valid, "pop from empty queue")

endmodule

FILE: rtl/core/fbb_back.sv
// Back end: column and row counters, edge tracking and the result register.
// Depends on fbb_pkg and the assertion macro header.
`include "foreground_bounding_box_assert.svh"
module fbb_back import fbb_pkg::*; #(
  parameter int MAX_SIDE = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_wr_t            cfg,
  input  logic               q_valid,
  input  logic               q_fg,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [4*OUT_W-1:0] m_fields,
  output logic               m_found
);

  localparam int CNT_W = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = (SW > SIZE_W) ? SW : SIZE_W;
  localparam int LEFT_RESET = (4096 > MAX_SIDE) ? MAX_SIDE : 4096;

  function automatic logic [SW-1:0] clamp_side(input logic [SIZE_W-1:0] v);
    logic [CW-1:0] vx;
    vx = CW'(v);
    if (v == '0) begin
      return SW'(1);
    end else if (vx > CW'(MAX_SIDE)) begin
      return SW'(MAX_SIDE);
    end
    return SW'(vx);
  endfunction

  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  row;
  logic [SW-1:0]     left;
  logic [SW-1:0]     right;
  logic [CNT_W-1:0]  top;
  logic [SW-1:0]     bottom;
  logic              top_seen;
  logic              row_hit;

  logic [SW-1:0]    w_eff;
  logic [SW-1:0]    h_eff;
  logic             col_last;
  logic             row_last;
  logic             frame_last;
  logic             hit;
  logic [SW-1:0]    left_next;
  logic [SW-1:0]    right_next;
  logic [CNT_W-1:0] top_next;
  logic [SW-1:0]    bottom_next;
  logic             seen_next;
  logic             emit;

  always_comb begin
    w_eff       = clamp_side(image_width);
    h_eff       = clamp_side(image_height);
    col_last    = (SW'(col) + SW'(1)) >= w_eff;
    row_last    = (SW'(row) + SW'(1)) >= h_eff;
    frame_last  = col_last && row_last;
    q_pop       = q_valid && (!frame_last || !m_tvalid || m_tready);
    emit        = q_pop && frame_last;
    hit         = row_hit || q_fg;
    left_next   = (q_fg && (SW'(col) < left)) ? SW'(col) : left;
    right_next  = (q_fg && (SW'(col) >= right)) ? SW'(col) + SW'(1) : right;
    top_next    = top;
    bottom_next = bottom;
    seen_next   = top_seen;
    if (col_last && hit) begin
      if (!top_seen) begin
        top_next = row;
      end
      seen_next   = 1'b1;
      bottom_next = SW'(row) + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
      col          <= '0;
      row          <= '0;
      left         <= SW'(LEFT_RESET);
      right        <= '0;
      top          <= '0;
      bottom       <= '0;
      top_seen     <= 1'b0;
      row_hit      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (q_pop) begin
        if (frame_last) begin
          col      <= '0;
          row      <= '0;
          left     <= w_eff;
          right    <= '0;
          top      <= '0;
          bottom   <= '0;
          top_seen <= 1'b0;
          row_hit  <= 1'b0;
        end else if (col_last) begin
          col      <= '0;
          row      <= row + 1'b1;
          left     <= left_next;
          right    <= right_next;
          top      <= top_next;
          bottom   <= bottom_next;
          top_seen <= seen_next;
          row_hit  <= 1'b0;
        end else begin
          col     <= col + 1'b1;
          left    <= left_next;
          right   <= right_next;
          row_hit <= hit;
        end
      end
      if (cfg.wr) begin
        case (cfg.index)
          REG_IMAGE_WIDTH: begin
            image_width <= cfg.data;
            if (right == '0) begin
              left <= clamp_side(cfg.data);
            end
          end
          REG_IMAGE_HEIGHT: image_height <= cfg.data;
          default: ;
        endcase
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_found <= seen_next;
      if (seen_next) begin
        m_fields <= {OUT_W'(bottom_next) - OUT_W'(top_next),
                     OUT_W'(right_next) - OUT_W'(left_next),
                     OUT_W'(0) - OUT_W'(top_next),
                     OUT_W'(0) - OUT_W'(left_next)};
      end else begin
        m_fields <= '0;
      end
    end
  end

  `FBB_ASSERT(a_empty_zero, clk, rst, m_tvalid && !m_found |-> m_fields == '0, "empty frame result not zero")
  `FBB_ASSERT(a_row_wrap, clk, rst, q_pop && col_last && !frame_last |=> col == '0 && row == $past(row) + 1'b1, "row advance wrong")
  `FBB_ASSERT(a_seen_right, clk, rst, top_seen |-> right != '0, "foreground row without right edge")

endmodule

FILE: rtl/core/foreground_bounding_box.sv
// Foreground bounding box: a new pixel can be accepted every cycle.
// A frame's result is registered after the last pixel of the frame leaves the queue.
// Input stalls only while the queue is full, i.e. when a frame result waits
// on the result port. Synchronous reset clears the queue pointers, counters
// and result valid, and resets the config registers, but not the result data.
module foreground_bounding_box import fbb_pkg::*; #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // pixel_red, pixel_green, pixel_blue, pixel_alpha
  input  logic [31:0]            s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // offset_x, offset_y, box_width, box_height, zero pad
  output logic [55:0]            m_tdata,
  // found
  output logic                   m_tuser
);

  cfg_wr_t            cfg;
  logic               q_full;
  logic               q_push;
  logic               q_push_fg;
  logic               q_pop;
  logic               q_valid;
  logic               q_fg;
  logic [4*OUT_W-1:0] fields;

  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign m_tdata   = {4'b0000, fields};

  fbb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .pixel    (pixel_t'(s_tdata)),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_fg     (q_push_fg)
  );

  fbb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_fg    (q_push_fg),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_fg    (q_fg)
  );

  fbb_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_fg     (q_fg),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_fields (fields),
    .m_found  (m_tuser)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for foreground_bounding_box: raster pixel frames in, one box per frame out.
// A scoreboard class predicts each frame's box and checks it against the result port.
// Depends on fbb_pkg and the foreground_bounding_box RTL only.
module tb_top;
  import fbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIDE = 4096;
  localparam int ITEMS = 2000;
  localparam int HOLD_CYCLES = 4;
  localparam int unsigned RUN_CAP = 64;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic              found;
    logic [OUT_W-1:0]  offset_x;
    logic [OUT_W-1:0]  offset_y;
    logic [OUT_W-1:0]  box_width;
    logic [OUT_W-1:0]  box_height;
  } box_t;

  class bbox_scoreboard;
    bit                    mode;
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [7:0]            key_r, key_g, key_b;
    int unsigned           col, row, left, right, top, bottom;
    bit                    top_seen, row_hit;
    box_t                  expected_boxes[$];
    int                    errors;

    function int unsigned side(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
    endfunction

    function void clear_frame();
      col = 0;
      row = 0;
      left = side(width_reg);
      right = 0;
      top = 0;
      bottom = 0;
      top_seen = 0;
      row_hit = 0;
    endfunction

    function void reset_state();
      mode = 0;
      width_reg = SIZE_RESET;
      height_reg = SIZE_RESET;
      key_r = 0;
      key_g = 0;
      key_b = 0;
      errors = 0;
      expected_boxes.delete();
      clear_frame();
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MATCH_MODE: mode = data[0];
        REG_IMAGE_WIDTH: begin
          width_reg = data;
          if (right == 0) left = side(width_reg);
        end
        REG_IMAGE_HEIGHT: height_reg = data;
        REG_KEY_RED: key_r = data[7:0];
        REG_KEY_GREEN: key_g = data[7:0];
        REG_KEY_BLUE: key_b = data[7:0];
        default: ;
      endcase
    endfunction

    // Pixels still needed to close the current frame, given the present sizes.
    function int unsigned frame_left();
      int unsigned w, h, total;
      w = side(width_reg);
      h = side(height_reg);
      total = (col < w) ? w - col : 1;
      if (row + 1 < h) total += (h - row - 1) * w;
      return total;
    endfunction

    function void note_pixel(pixel_t px);
      int unsigned w, h;
      bit fg;
      box_t box;
      w = side(width_reg);
      h = side(height_reg);
      if (mode) fg = (px.red != key_r) || (px.green != key_g) || (px.blue != key_b);
      else fg = (px.alpha != 0);
      if (fg) begin
        row_hit = 1;
        if (col < left) left = col;
        if (col >= right) right = col + 1;
      end
      if (col + 1 < w) begin
        col++;
        return;
      end
      if (row_hit) begin
        if (!top_seen) begin
          top = row;
          top_seen = 1;
        end
        bottom = row + 1;
      end
      row_hit = 0;
      col = 0;
      if (row + 1 < h) begin
        row++;
        return;
      end
      box = '0;
      if (top_seen) begin
        box.found = 1'b1;
        box.offset_x = OUT_W'(0 - left);
        box.offset_y = OUT_W'(0 - top);
        box.box_width = OUT_W'(right - left);
        box.box_height = OUT_W'(bottom - top);
      end
      expected_boxes.push_back(box);
      clear_frame();
    endfunction

    function void check_field(string name, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v,
                              bit is_signed);
      if (exp_v !== act_v) begin
        errors++;
        if (is_signed)
          $error("%s: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
        else
          $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      end
    endfunction

    function void check_box(logic found, logic [55:0] data);
      box_t exp_box;
      if (expected_boxes.size() == 0) begin
        errors++;
        $error("result transfer with no frame result pending");
        return;
      end
      exp_box = expected_boxes.pop_front();
      check_field("found", OUT_W'(exp_box.found), OUT_W'(found), 0);
      check_field("offset_x", exp_box.offset_x, data[12:0], 1);
      check_field("offset_y", exp_box.offset_y, data[25:13], 1);
      check_field("box_width", exp_box.box_width, data[38:26], 0);
      check_field("box_height", exp_box.box_height, data[51:39], 0);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [31:0]            s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [55:0]            m_tdata;
  logic                   m_tuser;

  bbox_scoreboard sb = new;
  int  pixels_sent = 0;
  bit  quiet = 0;

  foreground_bounding_box #(.MAX_SIDE(MAX_SIDE)) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_box(m_tuser, m_tdata);
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input pixel_t px);
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_px(input logic [7:0] r, g, b, a);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.alpha = a;
    send_pixel(px);
  endtask

  task automatic sender_pause();
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic pixel_t make_pixel(bit fg);
    pixel_t px;
    px = $urandom;
    if (sb.mode) begin
      if (!fg) begin
        px.red = sb.key_r;
        px.green = sb.key_g;
        px.blue = sb.key_b;
      end else begin
        case ($urandom_range(0, 3))
          0: px = {px.alpha, sb.key_b, sb.key_g, sb.key_r ^ 8'($urandom_range(1, 255))};
          1: px = {px.alpha, sb.key_b, sb.key_g ^ 8'($urandom_range(1, 255)), sb.key_r};
          2: px = {px.alpha, sb.key_b ^ 8'($urandom_range(1, 255)), sb.key_g, sb.key_r};
          default: ;
        endcase
      end
    end else if (!fg) begin
      px.alpha = 8'd0;
    end else if (px.alpha == 0) begin
      px.alpha = 8'($urandom_range(1, 255));
    end
    return px;
  endfunction

  task automatic send_run(input int unsigned n, input int unsigned permille);
    for (int unsigned i = 0; i < n; i++) begin
      sender_pause();
      send_pixel(make_pixel($urandom_range(0, 999) < permille));
    end
  endtask

  task automatic wait_for_boxes();
    s_tvalid <= 1'b0;
    while (sb.expected_boxes.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  // Holds cfg_valid high across back-to-back writes; the caller lowers it.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  function automatic logic [CFG_DATA_W-1:0] key_value();
    logic [7:0] k;
    case ($urandom_range(0, 3))
      0: k = 8'd0;
      1: k = 8'd255;
      default: k = 8'($urandom);
    endcase
    return {5'($urandom), k};
  endfunction

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 2;
      2: return 30;
      3: return 150;
      4: return 500;
      default: return 1000;
    endcase
  endfunction

  // Width and height are always written as a pair so a frame never exceeds MAX_SIDE pixels.
  task automatic change_settings();
    logic [CFG_DATA_W-1:0] w, h;
    wait_for_boxes();
    case ($urandom_range(0, 9))
      0: begin
        w = $urandom_range(0, 1) ? 13'd4096 : 13'($urandom_range(4097, 8191));
        h = 13'($urandom_range(0, 1));
      end
      1: begin
        w = 13'($urandom_range(0, 1));
        h = $urandom_range(0, 1) ? 13'd4096 : 13'($urandom_range(4097, 8191));
      end
      default: begin
        w = 13'($urandom_range(0, 8));
        h = 13'($urandom_range(0, 6));
      end
    endcase
    if ($urandom_range(0, 1)) cfg_write(REG_MATCH_MODE, 13'($urandom));
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
    if ($urandom_range(0, 1)) begin
      cfg_write(REG_KEY_RED, key_value());
      cfg_write(REG_KEY_GREEN, key_value());
      cfg_write(REG_KEY_BLUE, key_value());
    end
    if ($urandom_range(0, 7) == 0)
      cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 13'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned n;
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    cfg_write(REG_MATCH_MODE, 13'd0);
    cfg_write(REG_IMAGE_WIDTH, 13'd4);
    cfg_write(REG_IMAGE_HEIGHT, 13'd2);
    cfg_write(REG_KEY_RED, 13'd0);
    cfg_write(REG_SPARE_A, 13'h1fff);
    cfg_valid <= 1'b0;
    send_px(8'd0, 8'd0, 8'd0, 8'd0);
    send_px(8'd255, 8'd255, 8'd255, 8'd1);
    send_px(8'd0, 8'd0, 8'd0, 8'd0);
    send_px(8'd255, 8'd255, 8'd255, 8'd0);
    send_px(8'd0, 8'd0, 8'd0, 8'd0);
    send_px(8'd0, 8'd0, 8'd0, 8'd0);
    send_px(8'd0, 8'd0, 8'd0, 8'd255);
    send_px(8'd0, 8'd0, 8'd0, 8'd0);

    // Zero sizes behave as a single pixel per frame.
    wait_for_boxes();
    cfg_write(REG_IMAGE_WIDTH, 13'd0);
    cfg_write(REG_IMAGE_HEIGHT, 13'd0);
    cfg_valid <= 1'b0;
    send_px(8'd255, 8'd255, 8'd255, 8'd0);
    send_px(8'd17, 8'd170, 8'd85, 8'd128);

    wait_for_boxes();
    cfg_write(REG_MATCH_MODE, 13'd1);
    cfg_write(REG_IMAGE_WIDTH, 13'd3);
    cfg_write(REG_IMAGE_HEIGHT, 13'd2);
    cfg_write(REG_KEY_RED, 13'd255);
    cfg_write(REG_KEY_GREEN, 13'd0);
    cfg_write(REG_KEY_BLUE, 13'd255);
    cfg_write(REG_SPARE_B, 13'd5);
    cfg_valid <= 1'b0;
    send_px(8'd255, 8'd0, 8'd255, 8'd255);
    // Width shrinks mid-frame before any foreground has been seen.
    wait_for_boxes();
    cfg_write(REG_IMAGE_WIDTH, 13'd2);
    cfg_valid <= 1'b0;
    send_px(8'd255, 8'd0, 8'd255, 8'd0);
    send_px(8'd0, 8'd0, 8'd255, 8'd0);
    send_px(8'd255, 8'd1, 8'd255, 8'd255);
    send_px(8'd255, 8'd0, 8'd254, 8'd0);
    send_px(8'd255, 8'd0, 8'd255, 8'd0);

    change_settings();
    while (pixels_sent < ITEMS) begin
      if (pixels_sent > ITEMS * 17 / 20) quiet = 1;
      case ($urandom_range(0, 11))
        0: change_settings();
        1: begin
          n = sb.frame_left();
          if (n > 1) send_run($urandom_range(1, n - 1), pick_density());
        end
        2: wait_for_boxes();
        default: begin
          n = sb.frame_left();
          if (n > RUN_CAP) n = RUN_CAP;
          send_run(n, pick_density());
        end
      endcase
    end

    s_tvalid <= 1'b0;
    while (sb.expected_boxes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
